### rtl/core/usb_standard_request_decoder_core_assert.svh
// Assertion macros for the USB standard request decoder core.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef USB_STANDARD_REQUEST_DECODER_CORE_ASSERT_SVH
`define USB_STANDARD_REQUEST_DECODER_CORE_ASSERT_SVH

`ifndef SYNTH
// Clocked assertion that is switched off while reset is asserted.
`define USBSRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked during reset as well.
`define USBSRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define USBSRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define USBSRD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/usbsrd_pkg.sv
// Shared types, codes and sizes of the USB standard request decoder.
// Used by usbsrd_decode and usb_standard_request_decoder_core.
package usbsrd_pkg;

  localparam int unsigned MaxInterfaces = 16;
  localparam int unsigned MaxEndpoints  = 16;
  localparam int unsigned IfIdxW = (MaxInterfaces > 1) ? $clog2(MaxInterfaces) : 1;

  typedef enum logic [1:0] {
    ActDataIn    = 2'd0,
    ActStatusIn  = 2'd1,
    ActStall     = 2'd2,
    ActResetDone = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    SrcReply     = 3'd0,
    SrcDevice    = 3'd1,
    SrcConfig    = 3'd2,
    SrcString    = 3'd3,
    SrcQualifier = 3'd4
  } src_e;

  typedef enum logic [1:0] {
    StDefault    = 2'd0,
    StAddressed  = 2'd1,
    StConfigured = 2'd2
  } dev_st_e;

  localparam logic [7:0] ReqGetStatus  = 8'd0;
  localparam logic [7:0] ReqClrFeature = 8'd1;
  localparam logic [7:0] ReqSetFeature = 8'd3;
  localparam logic [7:0] ReqSetAddress = 8'd5;
  localparam logic [7:0] ReqGetDesc    = 8'd6;
  localparam logic [7:0] ReqGetConfig  = 8'd8;
  localparam logic [7:0] ReqSetConfig  = 8'd9;
  localparam logic [7:0] ReqGetIface   = 8'd10;
  localparam logic [7:0] ReqSetIface   = 8'd11;

  localparam logic [4:0] RcpDevice = 5'd0;
  localparam logic [4:0] RcpIface  = 5'd1;
  localparam logic [4:0] RcpEp     = 5'd2;

  localparam logic [7:0] DescDevice    = 8'd1;
  localparam logic [7:0] DescConfig    = 8'd2;
  localparam logic [7:0] DescString    = 8'd3;
  localparam logic [7:0] DescQualifier = 8'd6;

  localparam logic [1:0] RegNumCfg = 2'd0;
  localparam logic [1:0] RegNumStr = 2'd1;
  localparam logic [1:0] RegNumIf  = 2'd2;
  localparam logic [1:0] RegNumEp  = 2'd3;

  typedef struct packed {
    logic [7:0] num_cfg;
    logic [7:0] num_str;
    logic [4:0] num_if;
    logic [4:0] num_ep;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
  } req_t;

  typedef struct packed {
    dev_st_e     st;
    logic [6:0]  addr;
    logic [7:0]  cfg;
    logic [15:0] halt_in;
    logic [15:0] halt_out;
  } dev_t;

  typedef struct packed {
    logic              clear;
    logic              we;
    logic [IfIdxW-1:0] idx;
    logic [7:0]        val;
  } alt_upd_t;

  typedef struct packed {
    action_e     action;
    src_e        src;
    logic [7:0]  di;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] rlen;
    logic        au;
    logic [6:0]  addr;
    dev_st_e     st;
  } res_t;

endpackage

### rtl/core/usbsrd_decode.sv
// Combinational decode of one setup word against the current device state.
// Depends on usbsrd_pkg.
module usbsrd_decode (
  input  usbsrd_pkg::req_t     req_i,
  input  usbsrd_pkg::dev_t     dev_i,
  input  usbsrd_pkg::cfg_t     cfg_i,
  input  logic [7:0]           alt_rd_i,
  output usbsrd_pkg::res_t     res_o,
  output usbsrd_pkg::dev_t     dev_next_o,
  output usbsrd_pkg::alt_upd_t alt_upd_o
);

  logic [4:0]  recip;
  logic        standard;
  logic        dir_in;
  logic [6:0]  ep;
  logic        ep_in;
  logic [7:0]  iface;
  logic        iface_ok;
  logic        ep_ok;
  logic        ok;
  logic [15:0] mask;
  logic [15:0] bit_sel;

  assign recip    = req_i.rtype[4:0];
  assign standard = (req_i.rtype[6:5] == 2'b00);
  assign dir_in   = req_i.rtype[7];
  assign ep       = req_i.index[6:0];
  assign ep_in    = req_i.index[7];
  assign iface    = req_i.index[7:0];
  assign iface_ok = (iface < {3'b000, cfg_i.num_if}) &&
                    (iface < 8'(usbsrd_pkg::MaxInterfaces));
  assign ep_ok    = (ep != 7'd0) && (ep < {2'b00, cfg_i.num_ep}) &&
                    (ep < 7'(usbsrd_pkg::MaxEndpoints));
  assign mask     = ep_in ? dev_i.halt_in : dev_i.halt_out;
  assign bit_sel  = 16'd1 << ep[3:0];

  always_comb begin
    res_o      = '0;
    dev_next_o = dev_i;
    alt_upd_o  = '0;
    alt_upd_o.idx = iface[usbsrd_pkg::IfIdxW-1:0];
    alt_upd_o.val = req_i.value[7:0];
    ok = 1'b0;

    if (req_i.func) begin
      dev_next_o = '0;
      alt_upd_o.clear = 1'b1;
      res_o.action = usbsrd_pkg::ActResetDone;
    end else if (req_i.length != 16'd0) begin
      if (standard && dir_in) begin
        unique case (req_i.code)
          usbsrd_pkg::ReqGetDesc: begin
            if (recip == usbsrd_pkg::RcpDevice) begin
              if (req_i.value[15:8] == usbsrd_pkg::DescDevice) begin
                ok = 1'b1;
                res_o.src = usbsrd_pkg::SrcDevice;
              end else if (req_i.value[15:8] == usbsrd_pkg::DescConfig &&
                           req_i.value[7:0] < cfg_i.num_cfg) begin
                ok = 1'b1;
                res_o.src = usbsrd_pkg::SrcConfig;
                res_o.di  = req_i.value[7:0];
              end else if (req_i.value[15:8] == usbsrd_pkg::DescString &&
                           req_i.value[7:0] < cfg_i.num_str) begin
                ok = 1'b1;
                res_o.src = usbsrd_pkg::SrcString;
                res_o.di  = req_i.value[7:0];
              end else if (req_i.value[15:8] == usbsrd_pkg::DescQualifier) begin
                ok = 1'b1;
                res_o.src = usbsrd_pkg::SrcQualifier;
              end
              if (ok) res_o.rlen = req_i.length;
            end
          end
          usbsrd_pkg::ReqGetConfig: begin
            if (recip == usbsrd_pkg::RcpDevice && req_i.value == 16'd0 &&
                req_i.index == 16'd0 && req_i.length == 16'd1 &&
                dev_i.st != usbsrd_pkg::StDefault) begin
              ok = 1'b1;
              res_o.b0   = dev_i.cfg;
              res_o.rlen = 16'd1;
            end
          end
          usbsrd_pkg::ReqGetStatus: begin
            if (req_i.value == 16'd0 && req_i.length == 16'd2) begin
              if (recip == usbsrd_pkg::RcpDevice) begin
                ok = (req_i.index == 16'd0) && (dev_i.st != usbsrd_pkg::StDefault);
              end else if (recip == usbsrd_pkg::RcpIface) begin
                ok = (dev_i.st == usbsrd_pkg::StConfigured) && iface_ok;
              end else if (recip == usbsrd_pkg::RcpEp) begin
                ok = (ep == 7'd0 && dev_i.st != usbsrd_pkg::StDefault) ||
                     (ep_ok && dev_i.st == usbsrd_pkg::StConfigured);
                // Endpoints 16 and up fail the endpoint check and stall, so only endpoints below 16 read a halt bit.
                if (ok && ep[6:4] == 3'd0) res_o.b0 = {7'd0, mask[ep[3:0]]};
              end
              if (ok) res_o.rlen = 16'd2;
            end
          end
          usbsrd_pkg::ReqGetIface: begin
            if (req_i.value == 16'd0 && req_i.length == 16'd1 &&
                recip == usbsrd_pkg::RcpIface &&
                dev_i.st == usbsrd_pkg::StConfigured && iface_ok) begin
              ok = 1'b1;
              res_o.b0   = alt_rd_i;
              res_o.rlen = 16'd1;
            end
          end
          default: ok = 1'b0;
        endcase
      end
      res_o.action = ok ? usbsrd_pkg::ActDataIn : usbsrd_pkg::ActStall;
    end else begin
      if (standard && !dir_in) begin
        unique case (req_i.code) inside
          usbsrd_pkg::ReqSetAddress: begin
            if (dev_i.st != usbsrd_pkg::StConfigured &&
                recip == usbsrd_pkg::RcpDevice) begin
              ok = 1'b1;
              res_o.au = 1'b1;
              dev_next_o.addr = req_i.value[6:0];
              dev_next_o.st = (req_i.value[6:0] == 7'd0) ? usbsrd_pkg::StDefault
                                                         : usbsrd_pkg::StAddressed;
            end
          end
          usbsrd_pkg::ReqSetConfig: begin
            if (dev_i.st != usbsrd_pkg::StDefault && recip == usbsrd_pkg::RcpDevice) begin
              ok = 1'b1;
              dev_next_o.cfg = req_i.value[7:0];
              dev_next_o.st = (req_i.value[7:0] == 8'd0) ? usbsrd_pkg::StAddressed
                                                         : usbsrd_pkg::StConfigured;
            end
          end
          usbsrd_pkg::ReqClrFeature, usbsrd_pkg::ReqSetFeature: begin
            if (recip == usbsrd_pkg::RcpEp && ep_ok && req_i.value == 16'd0) begin
              ok = 1'b1;
              if (req_i.code == usbsrd_pkg::ReqSetFeature) begin
                if (ep_in) dev_next_o.halt_in  = dev_i.halt_in | bit_sel;
                else       dev_next_o.halt_out = dev_i.halt_out | bit_sel;
              end else begin
                if (ep_in) dev_next_o.halt_in  = dev_i.halt_in & ~bit_sel;
                else       dev_next_o.halt_out = dev_i.halt_out & ~bit_sel;
              end
            end
          end
          usbsrd_pkg::ReqSetIface: begin
            if (recip == usbsrd_pkg::RcpIface &&
                dev_i.st == usbsrd_pkg::StConfigured && iface_ok) begin
              ok = 1'b1;
              alt_upd_o.we = 1'b1;
            end
          end
          default: ok = 1'b0;
        endcase
      end
      res_o.action = ok ? usbsrd_pkg::ActStatusIn : usbsrd_pkg::ActStall;
    end

    res_o.addr = dev_next_o.addr;
    res_o.st   = dev_next_o.st;
  end

endmodule

### rtl/core/usb_standard_request_decoder_core.sv
// Top level of the USB standard request decoder: stream ports, APB registers,
// device state and the input and result registers. Depends on usbsrd_pkg,
// usbsrd_decode and usb_standard_request_decoder_core_assert.svh.
//
//   channel   direction  handshake               contents
//   s_axis    in         tvalid/tready           setup word, tuser = bus reset
//   m_axis    out        tvalid/tready           result word, tuser = action
//   apb       in         psel/penable/pready     four 32-bit registers
//
// A word passes from the input register to the result register, and one word
// is taken every cycle while the result is not stalled. The device state
// updates at the edge a word moves into the result register. Reset clears the
// device state, the APB registers, the alternate settings and both valid flags;
// the data registers are not reset. A stalled result only holds the input register once it is full.
module usb_standard_request_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] req_type, [15:8] request_code, [31:16] setup_value,
  // [47:32] setup_index, [63:48] setup_length
  input  logic [63:0] s_axis_tdata,
  // [0] func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] data_source, [10:3] descriptor_index, [18:11] reply_byte0,
  // [26:19] reply_byte1, [42:27] reply_length, [43] address_update,
  // [50:44] device_address, [52:51] device_state, [55:53] zero
  output logic [55:0] m_axis_tdata,
  // [1:0] action
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "usb_standard_request_decoder_core_assert.svh"

  usbsrd_pkg::cfg_t     cfg_q;
  usbsrd_pkg::dev_t     dev_q, dev_d;
  usbsrd_pkg::req_t     req_q;
  usbsrd_pkg::res_t     res_d;
  usbsrd_pkg::alt_upd_t alt_upd;
  logic [7:0]           alt_q [usbsrd_pkg::MaxInterfaces];
  logic [7:0]           alt_rd;
  logic                 in_valid_q;
  logic                 out_valid_q;
  logic [55:0]          out_data_q;
  logic [1:0]           out_user_q;
  logic                 advance;
  logic                 fire;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign advance = !out_valid_q || m_axis_tready;
  assign fire    = advance && in_valid_q;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_cfg <= 8'd1;
      cfg_q.num_str <= 8'd4;
      cfg_q.num_if  <= 5'd1;
      cfg_q.num_ep  <= 5'd4;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        usbsrd_pkg::RegNumCfg: cfg_q.num_cfg <= pwdata[7:0];
        usbsrd_pkg::RegNumStr: cfg_q.num_str <= pwdata[7:0];
        usbsrd_pkg::RegNumIf:  cfg_q.num_if  <= pwdata[4:0];
        usbsrd_pkg::RegNumEp:  cfg_q.num_ep  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      usbsrd_pkg::RegNumCfg: prdata = {24'd0, cfg_q.num_cfg};
      usbsrd_pkg::RegNumStr: prdata = {24'd0, cfg_q.num_str};
      usbsrd_pkg::RegNumIf:  prdata = {27'd0, cfg_q.num_if};
      usbsrd_pkg::RegNumEp:  prdata = {27'd0, cfg_q.num_ep};
      default:               prdata = 32'd0;
    endcase
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q.func   <= s_axis_tuser;
      req_q.rtype  <= s_axis_tdata[7:0];
      req_q.code   <= s_axis_tdata[15:8];
      req_q.value  <= s_axis_tdata[31:16];
      req_q.index  <= s_axis_tdata[47:32];
      req_q.length <= s_axis_tdata[63:48];
    end
  end

  assign alt_rd = alt_q[req_q.index[usbsrd_pkg::IfIdxW-1:0]];

  usbsrd_decode u_decode (
    .req_i      (req_q),
    .dev_i      (dev_q),
    .cfg_i      (cfg_q),
    .alt_rd_i   (alt_rd),
    .res_o      (res_d),
    .dev_next_o (dev_d),
    .alt_upd_o  (alt_upd)
  );

  // Device state moves only when a word leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= '0;
      for (int i = 0; i < usbsrd_pkg::MaxInterfaces; i++) alt_q[i] <= 8'd0;
    end else if (fire) begin
      dev_q <= dev_d;
      if (alt_upd.clear) begin
        for (int i = 0; i < usbsrd_pkg::MaxInterfaces; i++) alt_q[i] <= 8'd0;
      end else if (alt_upd.we) begin
        alt_q[alt_upd.idx] <= alt_upd.val;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_user_q <= res_d.action;
      out_data_q <= {3'd0, res_d.st, res_d.addr, res_d.au, res_d.rlen,
                     res_d.b1, res_d.b0, res_d.di, res_d.src};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `USBSRD_ASSERT(a_stall_empty, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser == usbsrd_pkg::ActStall) |-> (m_axis_tdata[42:0] == 43'd0 && m_axis_tdata[43] == 1'b0), "stall result carries payload")
  `USBSRD_ASSERT(a_addr_upd, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[43]) |-> (m_axis_tuser == usbsrd_pkg::ActStatusIn), "address update outside a status reply")
  `USBSRD_ASSERT(a_reset_done, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser == usbsrd_pkg::ActResetDone) |-> (m_axis_tdata[52:44] == 9'd0), "bus reset left device state")
  `USBSRD_ASSERT_ALWAYS(a_cfg_nonzero, clk_i, (dev_q.st == usbsrd_pkg::StConfigured) |-> (dev_q.cfg != 8'd0), "configured with configuration zero")

endmodule
